// ----- hw/rtl/pipd_pkg.sv -----
// Shared widths, register indexes, control states and unit status for the pump drive core.
// No dependencies; every other file of the block imports this package.
package pipd_pkg;

   localparam int HUM_WIDTH      = 11;
   localparam int ERR_WIDTH      = HUM_WIDTH + 1;
   localparam int GAIN_WIDTH     = 16;
   localparam int DRIVE_WIDTH    = 8;
   localparam int SAMPLE_WIDTH   = 8;
   localparam int TIME_WIDTH     = 20;
   localparam int FLOW_WIDTH     = 8;
   localparam int NOW_WIDTH      = 32;
   localparam int PROD_WIDTH     = TIME_WIDTH + FLOW_WIDTH;
   localparam int FRAC_BITS      = 12;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [TIME_WIDTH-1:0] EXP_MAX = '1;

   localparam logic [HUM_WIDTH-1:0]    TARGET_RST   = 11'd960;
   localparam logic [GAIN_WIDTH-1:0]   GAIN_P_RST   = 16'd256;
   localparam logic [GAIN_WIDTH-1:0]   GAIN_I_RST   = 16'd256;
   localparam logic [HUM_WIDTH-1:0]    BRAKE_RST    = 11'd0;
   localparam logic [DRIVE_WIDTH-1:0]  DRIVE_MIN_RST = 8'd0;
   localparam logic [DRIVE_WIDTH-1:0]  DRIVE_MAX_RST = 8'd255;
   localparam logic [SAMPLE_WIDTH-1:0] MIN_SAMP_RST = 8'd3;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TARGET      = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GAIN_P      = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GAIN_I      = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BRAKE       = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DRIVE_MIN   = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DRIVE_MAX   = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MIN_SAMPLES = 3'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } ctl_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

// ----- hw/rtl/pipd_req_if.sv -----
// Request channel: one humidity sample with its timestamp and history statistics.
// Depends on pipd_pkg.
interface pipd_req_if;
   import pipd_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [HUM_WIDTH-1:0]    humidity;
   logic                    history_valid;
   logic [SAMPLE_WIDTH-1:0] history_samples;
   logic [TIME_WIDTH-1:0]   history_avg_time_ms;
   logic [FLOW_WIDTH-1:0]   history_avg_flow;
   logic [NOW_WIDTH-1:0]    now_ms;

   modport source (output valid, humidity, history_valid, history_samples,
                   history_avg_time_ms, history_avg_flow, now_ms, input ready);
   modport sink   (input valid, humidity, history_valid, history_samples,
                   history_avg_time_ms, history_avg_flow, now_ms, output ready);
endinterface

// ----- hw/rtl/pipd_rsp_if.sv -----
// Response channel: one pump drive result per sample.
// Depends on pipd_pkg.
interface pipd_rsp_if;
   import pipd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [DRIVE_WIDTH-1:0] pump_drive;
   logic                   pump_on;
   logic                   historical_mode;
   logic [TIME_WIDTH-1:0]  expected_time_ms;

   modport source (output valid, pump_drive, pump_on, historical_mode, expected_time_ms,
                   input ready);
   modport sink   (input valid, pump_drive, pump_on, historical_mode, expected_time_ms,
                   output ready);
endinterface

// ----- hw/rtl/pipd_mac.sv -----
// Bit-serial dual multiply-accumulate: acc = a0*b0 + a1*b1, one multiplier bit per cycle.
// Depends on pipd_pkg. Multiplicands are pre-extended to DATA_WIDTH by the caller.
module pipd_mac #(
   parameter int DATA_WIDTH = 42
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [DATA_WIDTH-1:0]              a0,
   input  logic [DATA_WIDTH-1:0]              a1,
   input  logic [pipd_pkg::GAIN_WIDTH-1:0]    b0,
   input  logic [pipd_pkg::GAIN_WIDTH-1:0]    b1,
   output logic [DATA_WIDTH-1:0]              acc,
   output pipd_pkg::unit_stat_type            stat
);
   import pipd_pkg::*;

   localparam int CW = $clog2(GAIN_WIDTH + 1);

   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] a0_ff, a0_in, a1_ff, a1_in;
   logic [GAIN_WIDTH-1:0] b0_ff, b0_in, b1_ff, b1_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      a0_in   = a0_ff;
      a1_in   = a1_ff;
      b0_in   = b0_ff;
      b1_in   = b1_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a0_in   = a0;
         a1_in   = a1;
         b0_in   = b0;
         b1_in   = b1;
         cnt_in  = CW'(GAIN_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + (b0_ff[0] ? a0_ff : '0) + (b1_ff[0] ? a1_ff : '0);
         a0_in  = a0_ff << 1;
         a1_in  = a1_ff << 1;
         b0_in  = b0_ff >> 1;
         b1_in  = b1_ff >> 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a0_ff  <= a0_in;
      a1_ff  <= a1_in;
      b0_ff  <= b0_in;
      b1_ff  <= b1_in;
   end

   assign acc       = acc_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- hw/rtl/pipd_div.sv -----
// Bit-serial restoring divider for the history run limit: one quotient bit per cycle.
// Depends on pipd_pkg. Divisor must be nonzero; the caller handles a zero divisor.
module pipd_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [pipd_pkg::PROD_WIDTH-1:0]    dividend,
   input  logic [pipd_pkg::DRIVE_WIDTH-1:0]   divisor,
   output logic [pipd_pkg::PROD_WIDTH-1:0]    quotient,
   output pipd_pkg::unit_stat_type            stat
);
   import pipd_pkg::*;

   localparam int CW = $clog2(PROD_WIDTH + 1);

   logic [PROD_WIDTH-1:0]  quo_ff, quo_in;
   logic [DRIVE_WIDTH-1:0] rem_ff, rem_in;
   logic [DRIVE_WIDTH-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DRIVE_WIDTH:0]   trial;
   logic [DRIVE_WIDTH:0]   diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      // dividend bits shift out of the top while quotient bits enter at the bottom
      trial   = {rem_ff, quo_ff[PROD_WIDTH-1]};
      diff    = trial - {1'b0, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(PROD_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[DRIVE_WIDTH-1:0];
            quo_in = {quo_ff[PROD_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[DRIVE_WIDTH-1:0];
            quo_in = {quo_ff[PROD_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- hw/rtl/pi_pump_drive_with_history_cutoff_core.sv -----
// Pump drive controller: PI loop with output clamp and a history-based run limit. One
// transaction in gives one result out. In PI mode a sample passes through the bit-serial
// multiplier for the gains; in history mode the bit-serial divider for the run limit follows
// the multiplier, and history mode with a zero drive_max skips the divider. A stalled response
// adds its stall to the next result. The request side takes the next sample as soon as the
// controller is idle, even while a result waits on the response side. Configuration registers
// must be written only while no sample is in flight; the block itself does not enforce this.
module pi_pump_drive_with_history_cutoff_core #(
   parameter int INTEGRATOR_WIDTH = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   pipd_req_if.sink                             req_chan,
   pipd_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [pipd_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [pipd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import pipd_pkg::*;

   localparam int IW = INTEGRATOR_WIDTH;
   localparam int PW = IW + 18;          // product/accumulator width
   localparam int VW = PW - FRAC_BITS;   // width after the Q.12 shift

   // configuration
   logic [HUM_WIDTH-1:0]    target_ff, brake_ff;
   logic [GAIN_WIDTH-1:0]   gain_p_ff, gain_i_ff;
   logic [DRIVE_WIDTH-1:0]  dmin_ff, dmax_ff;
   logic [SAMPLE_WIDTH-1:0] min_samp_ff;

   // controller state
   ctl_state_type           state_ff, state_in;
   logic [IW-1:0]           integ_ff, integ_in;
   logic                    active_ff, active_in;
   logic [NOW_WIDTH-1:0]    run_start_ff, run_start_in;
   logic [HUM_WIDTH-1:0]    hum_ff;
   logic [NOW_WIDTH-1:0]    now_ff;
   logic                    usable_ff;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DRIVE_WIDTH-1:0]  rsp_drive_ff;
   logic                    rsp_on_ff, rsp_hist_ff;
   logic [TIME_WIDTH-1:0]   rsp_exp_ff;

   logic                    load, finish, mac_start, div_start;
   logic                    usable_in;
   logic signed [ERR_WIDTH-1:0] err;
   logic signed [IW+1:0]    integ_sum;
   logic [IW-1:0]           integ_sat;
   logic [IW-1:0]           integ_rewind;
   logic [PW-1:0]           mac_a0, mac_a1, mac_acc;
   logic [GAIN_WIDTH-1:0]   mac_b0, mac_b1;
   logic [PROD_WIDTH-1:0]   div_quo;
   unit_stat_type           mac_stat, div_stat;

   logic signed [VW-1:0]    pi_val;
   logic [DRIVE_WIDTH-1:0]  pi_drive, fin_drive;
   logic [TIME_WIDTH-1:0]   fin_exp;
   logic [NOW_WIDTH-1:0]    start_ms, elapsed;
   logic                    below;
   logic [DRIVE_WIDTH-1:0]  out_drive;
   logic                    out_on, out_hist;
   logic [IW-1:0]           fin_integ;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= TARGET_RST;
         gain_p_ff   <= GAIN_P_RST;
         gain_i_ff   <= GAIN_I_RST;
         brake_ff    <= BRAKE_RST;
         dmin_ff     <= DRIVE_MIN_RST;
         dmax_ff     <= DRIVE_MAX_RST;
         min_samp_ff <= MIN_SAMP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET:      target_ff   <= csr_wdata[HUM_WIDTH-1:0];
            CSR_GAIN_P:      gain_p_ff   <= csr_wdata;
            CSR_GAIN_I:      gain_i_ff   <= csr_wdata;
            CSR_BRAKE:       brake_ff    <= csr_wdata[HUM_WIDTH-1:0];
            CSR_DRIVE_MIN:   dmin_ff     <= csr_wdata[DRIVE_WIDTH-1:0];
            CSR_DRIVE_MAX:   dmax_ff     <= csr_wdata[DRIVE_WIDTH-1:0];
            CSR_MIN_SAMPLES: min_samp_ff <= csr_wdata[SAMPLE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // integrator update, evaluated as the sample is taken
   assign usable_in = req_chan.history_valid &&
                      (req_chan.history_samples >= min_samp_ff);
   assign err       = $signed({1'b0, target_ff}) - $signed({1'b0, req_chan.humidity});
   assign integ_sum = $signed({{2{integ_ff[IW-1]}}, integ_ff})
                    + $signed({{(IW+2-ERR_WIDTH){err[ERR_WIDTH-1]}}, err})
                    - $signed({{(IW+2-HUM_WIDTH){1'b0}}, brake_ff});

   always_comb begin
      // out of range when the three top bits disagree
      if (integ_sum[IW+1:IW-1] == 3'b000 || integ_sum[IW+1:IW-1] == 3'b111) begin
         integ_sat = integ_sum[IW-1:0];
      end else if (integ_sum[IW+1]) begin
         integ_sat = {1'b1, {(IW-1){1'b0}}};
      end else begin
         integ_sat = {1'b0, {(IW-1){1'b1}}};
      end
   end

   assign integ_rewind = {{(IW-DRIVE_WIDTH-4){1'b0}}, dmin_ff, 4'b0000};

   // multiplier operands: gains in PI mode, avg_time * avg_flow in history mode
   always_comb begin
      if (usable_in) begin
         mac_a0 = {{(PW-TIME_WIDTH){1'b0}}, req_chan.history_avg_time_ms};
         mac_b0 = {{(GAIN_WIDTH-FLOW_WIDTH){1'b0}}, req_chan.history_avg_flow};
         mac_a1 = '0;
         mac_b1 = '0;
      end else begin
         mac_a0 = {{(PW-ERR_WIDTH){err[ERR_WIDTH-1]}}, err};
         mac_b0 = gain_p_ff;
         mac_a1 = {{(PW-IW){integ_sat[IW-1]}}, integ_sat};
         mac_b1 = gain_i_ff;
      end
   end

   pipd_mac #(
      .DATA_WIDTH (PW)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .start (mac_start),
      .a0    (mac_a0),
      .a1    (mac_a1),
      .b0    (mac_b0),
      .b1    (mac_b1),
      .acc   (mac_acc),
      .stat  (mac_stat)
   );

   pipd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mac_acc[PROD_WIDTH-1:0]),
      .divisor  (dmax_ff),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      load      = 1'b0;
      finish    = 1'b0;
      mac_start = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               load      = 1'b1;
               mac_start = 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mac_stat.done) begin
               if (usable_ff && (dmax_ff != '0)) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in  = ST_FINISH;
               end
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   // result and state commit
   assign pi_val = $signed(mac_acc[PW-1:FRAC_BITS]);

   always_comb begin
      // clamp against max first, then min
      if (pi_val > $signed({{(VW-DRIVE_WIDTH){1'b0}}, dmax_ff})) begin
         pi_drive = dmax_ff;
      end else if (pi_val < $signed({{(VW-DRIVE_WIDTH){1'b0}}, dmin_ff})) begin
         pi_drive = dmin_ff;
      end else begin
         pi_drive = pi_val[DRIVE_WIDTH-1:0];
      end

      if (!usable_ff) begin
         fin_exp = '0;
      end else if (dmax_ff == '0 || div_quo > PROD_WIDTH'(EXP_MAX)) begin
         fin_exp = EXP_MAX;
      end else begin
         fin_exp = div_quo[TIME_WIDTH-1:0];
      end

      fin_drive = usable_ff ? dmax_ff : pi_drive;
      below     = hum_ff < target_ff;
      start_ms  = active_ff ? run_start_ff : now_ff;
      elapsed   = now_ff - start_ms;

      out_drive    = '0;
      out_on       = 1'b0;
      out_hist     = 1'b0;
      active_in    = 1'b0;
      run_start_in = run_start_ff;
      fin_integ    = integ_ff;
      if (below) begin
         run_start_in = start_ms;
         if (usable_ff) begin
            if (elapsed < {{(NOW_WIDTH-TIME_WIDTH){1'b0}}, fin_exp}) begin
               active_in = 1'b1;
               out_drive = fin_drive;
               out_on    = 1'b1;
               out_hist  = 1'b1;
            end else begin
               fin_integ = '0;   // history timeout
            end
         end else begin
            active_in = 1'b1;
            out_drive = fin_drive;
            out_on    = 1'b1;
         end
      end else begin
         fin_integ = integ_rewind;
      end
   end

   always_comb begin
      integ_in = integ_ff;
      if (load && !usable_in) begin
         integ_in = integ_sat;
      end else if (finish) begin
         integ_in = fin_integ;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         integ_ff     <= '0;
         active_ff    <= 1'b0;
         run_start_ff <= '0;
         rsp_valid_ff <= 1'b0;
         usable_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            usable_ff <= usable_in;
         end
         if (finish) begin
            active_ff    <= active_in;
            run_start_ff <= run_start_in;
         end
      end
      if (load) begin
         hum_ff <= req_chan.humidity;
         now_ff <= req_chan.now_ms;
      end
      if (finish) begin
         rsp_drive_ff <= out_drive;
         rsp_on_ff    <= out_on;
         rsp_hist_ff  <= out_hist;
         rsp_exp_ff   <= fin_exp;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.pump_drive       = rsp_drive_ff;
   assign rsp_chan.pump_on          = rsp_on_ff;
   assign rsp_chan.historical_mode  = rsp_hist_ff;
   assign rsp_chan.expected_time_ms = rsp_exp_ff;

endmodule

// ----- hw/rtl/pipd_checker.sv -----
// Port-level checks for the pump drive core, bound to the top level.
// Depends on pipd_pkg and pi_pump_drive_with_history_cutoff_core.
module pipd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [pipd_pkg::DRIVE_WIDTH-1:0]   pump_drive,
   input logic                               pump_on,
   input logic                               historical_mode,
   input logic [pipd_pkg::TIME_WIDTH-1:0]    expected_time_ms
);
   import pipd_pkg::*;

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pump_drive) && $stable(pump_on)
         && $stable(historical_mode) && $stable(expected_time_ms))
      else $error("result changed while stalled");

   // pump off means zero drive and no history run
   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !pump_on |-> pump_drive == '0 && !historical_mode)
      else $error("pump off with nonzero drive or history flag");

   // a history run always has a nonzero limit
   a_hist_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && historical_mode |-> pump_on && expected_time_ms != '0)
      else $error("history run without limit");

   // one sample at a time: busy right after a transaction is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a sample is in flight");

endmodule

bind pi_pump_drive_with_history_cutoff_core pipd_checker u_pipd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .pump_drive       (rsp_chan.pump_drive),
   .pump_on          (rsp_chan.pump_on),
   .historical_mode  (rsp_chan.historical_mode),
   .expected_time_ms (rsp_chan.expected_time_ms)
);
